[src/q4dq_pkg.sv]
package q4dq_pkg;

  // Field and datapath widths
  localparam int unsigned ACT_W  = 16;                  // Q3.12 activation / scale
  localparam int unsigned WB_W   = 8;                   // packed weight byte
  localparam int unsigned NIB_W  = 4;                   // one weight nibble
  localparam int unsigned PROD_W = NIB_W + ACT_W;       // nibble x activation
  localparam int unsigned PAIR_W = PROD_W + 1;          // sum of both products
  localparam int unsigned TERM_W = PAIR_W + ACT_W;      // pair x scale, Q.24
  localparam int unsigned ACC_W  = 48;                  // Q23.24 accumulator

  // Saturation limits of the accumulator
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Default depth of the queue between front and back
  localparam int unsigned DEF_Q_DEPTH = 4;

  // One classified beat as it sits in the queue
  typedef struct packed {
    logic signed [PAIR_W-1:0] pair;
    logic signed [ACT_W-1:0]  scale;
    logic                     last;
  } q_entry_t;

endpackage

[src/q4dq_front.sv]
module q4dq_front (
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [q4dq_pkg::WB_W-1:0]           weight_byte_i,
  input  logic signed [q4dq_pkg::ACT_W-1:0]   block_scale_i,
  input  logic signed [q4dq_pkg::ACT_W-1:0]   act_even_i,
  input  logic signed [q4dq_pkg::ACT_W-1:0]   act_odd_i,
  input  logic                                last_pair_i,
  input  logic                                full_i,
  output logic                                push_o,
  output q4dq_pkg::q_entry_t                  push_data_o
);

  logic signed [q4dq_pkg::NIB_W-1:0]  w_even;
  logic signed [q4dq_pkg::NIB_W-1:0]  w_odd;
  logic signed [q4dq_pkg::PROD_W-1:0] prod_even;
  logic signed [q4dq_pkg::PROD_W-1:0] prod_odd;

  // nibble - 8 is the nibble with its top bit flipped, read as signed
  assign w_even = {~weight_byte_i[3], weight_byte_i[2:0]};
  assign w_odd  = {~weight_byte_i[7], weight_byte_i[6:4]};

  // Two narrow products and their sum
  assign prod_even = q4dq_pkg::PROD_W'(w_even) * q4dq_pkg::PROD_W'(act_even_i);
  assign prod_odd  = q4dq_pkg::PROD_W'(w_odd)  * q4dq_pkg::PROD_W'(act_odd_i);

  // Beat goes into the queue whenever there is room
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  always_comb begin
    push_data_o.pair  = q4dq_pkg::PAIR_W'(prod_even) + q4dq_pkg::PAIR_W'(prod_odd);
    push_data_o.scale = block_scale_i;
    push_data_o.last  = last_pair_i;
  end

endmodule

[src/q4dq_queue.sv]
module q4dq_queue #(
  parameter int unsigned DEPTH = q4dq_pkg::DEF_Q_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  q4dq_pkg::q_entry_t             push_data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic                           pop_valid_o,
  output q4dq_pkg::q_entry_t             pop_data_o,
  output logic [$clog2(DEPTH+1)-1:0]     level_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  q4dq_pkg::q_entry_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o      = (cnt_q == FULL_CNT);
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign level_o     = cnt_q;

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & pop_valid_o;

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/q4dq_back.sv]
module q4dq_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  q4dq_pkg::q_entry_t                 q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [q4dq_pkg::ACC_W-1:0]  dot_value_o
);

  localparam int unsigned SUM_W = q4dq_pkg::ACC_W + 1;

  logic                                s1_vld_q;
  logic                                s1_last_q;
  logic signed [q4dq_pkg::TERM_W-1:0]  s1_term_q;
  logic signed [q4dq_pkg::TERM_W-1:0]  s1_term_d;
  logic signed [q4dq_pkg::ACC_W-1:0]   acc_q;
  logic                                out_vld_q;
  logic signed [q4dq_pkg::ACC_W-1:0]   out_q;
  logic signed [SUM_W-1:0]             sum_wide;
  logic signed [q4dq_pkg::ACC_W-1:0]   sum_sat;
  logic                                out_free;
  logic                                s1_adv;

  assign out_free = ~out_vld_q | ~out_stall_i;
  // A last beat needs the output register; others just accumulate
  assign s1_adv   = s1_vld_q & (~s1_last_q | out_free);
  assign q_pop_o  = q_valid_i & (~s1_vld_q | s1_adv);

  // Stage 1: scale the pair sum
  assign s1_term_d = q4dq_pkg::TERM_W'(q_data_i.pair) * q4dq_pkg::TERM_W'(q_data_i.scale);

  // Stage 2: accumulate with saturation at the 48-bit limits
  assign sum_wide = SUM_W'(acc_q) + SUM_W'(s1_term_q);
  always_comb begin
    if (sum_wide[SUM_W-1] != sum_wide[SUM_W-2]) begin
      sum_sat = sum_wide[SUM_W-1] ? q4dq_pkg::ACC_MIN : q4dq_pkg::ACC_MAX;
    end else begin
      sum_sat = sum_wide[q4dq_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        s1_vld_q  <= 1'b1;
        s1_last_q <= q_data_i.last;
      end else if (s1_adv) begin
        s1_vld_q  <= 1'b0;
      end
      if (s1_adv) begin
        acc_q <= s1_last_q ? '0 : sum_sat;
      end
      if (s1_adv && s1_last_q) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_term_q <= s1_term_d;
    end
    if (s1_adv && s1_last_q) begin
      out_q <= sum_sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign dot_value_o = out_q;

endmodule

[src/q4_0_dequant_dot_product_unit.sv]
// Channel | Signals                                          | Dir | Beat
// --------+--------------------------------------------------+-----+--------------------------
// in      | in_valid_i, in_stall_o, weight_byte_i,           | in  | one Q4_0 byte, two acts,
//         | block_scale_i, act_even_i, act_odd_i, last_pair_i|     | scale and last flag
// out     | out_valid_o, out_stall_i, dot_value_o            | out | one finished dot product
//
// Takes one byte per cycle; the input side stalls only when the queue is full.
// A result's last byte is written into the queue at the accepting edge, then
// passes the scale multiplier register and the accumulate/output register.
// Reset (rst_ni low, async) empties the queue and pipeline and clears the sum.
// An output stall only holds back a beat marked last; it waits in stage 1,
// later beats wait in the queue, and in_stall_o rises once the queue fills.
module q4_0_dequant_dot_product_unit #(
  parameter int unsigned Q_DEPTH = q4dq_pkg::DEF_Q_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [q4dq_pkg::WB_W-1:0]          weight_byte_i,
  input  logic signed [q4dq_pkg::ACT_W-1:0]  block_scale_i,
  input  logic signed [q4dq_pkg::ACT_W-1:0]  act_even_i,
  input  logic signed [q4dq_pkg::ACT_W-1:0]  act_odd_i,
  input  logic                               last_pair_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [q4dq_pkg::ACC_W-1:0]  dot_value_o
);

  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

  logic               push;
  logic               full;
  logic               pop;
  logic               pop_valid;
  q4dq_pkg::q_entry_t push_data;
  q4dq_pkg::q_entry_t pop_data;
  logic [CNT_W-1:0]   level;

  // Front: unpack nibbles, form the pair sum
  q4dq_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .weight_byte_i (weight_byte_i),
    .block_scale_i (block_scale_i),
    .act_even_i    (act_even_i),
    .act_odd_i     (act_odd_i),
    .last_pair_i   (last_pair_i),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Decoupling queue
  q4dq_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .level_o     (level)
  );

  // Back: scale, accumulate, emit
  q4dq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dot_value_o (dot_value_o)
  );

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) level <= FULL_CNT)
    else $error("queue level above depth");

  // Input stalls exactly when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o == (level == FULL_CNT))
    else $error("input stall disagrees with queue level");

  // An accepted beat leaves the queue non-empty next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (level != '0))
    else $error("accepted beat lost from queue");

endmodule
